// ----- hdl/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, codes and constants of the fragmenting frame builder.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SENDER_ADDRESS   = 3'd0,
      CSR_RECEIVER_ADDRESS = 3'd1,
      CSR_PAYLOAD_MAX      = 3'd2,
      CSR_PROTOCOL_BIT     = 3'd3,
      CSR_CHECKSUM_TYPE    = 3'd4,
      CSR_MESSAGE_TYPE     = 3'd5,
      CSR_CRC_POLYNOMIAL   = 3'd6
   } csr_index_type;

   localparam logic       MODE_START        = 1'b0;
   localparam logic [7:0] FLAG_BYTE         = 8'h7E;
   localparam logic [7:0] ESC_BYTE          = 8'h7D;
   localparam logic [15:0] FIXED_CHECK      = 16'hC3C3;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [7:0] PAYLOAD_MAX_RESET = 8'd32;
   localparam logic [15:0] POLY_RESET       = 16'hA001;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CRC,
      ST_ESC,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      PH_FLAG_OPEN,
      PH_CTRL_HI,
      PH_CTRL_LO,
      PH_SENDER,
      PH_RECEIVER,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHK_HI,
      PH_CHK_LO,
      PH_FLAG_CLOSE
   } phase_type;

   typedef struct packed {
      logic       seed;
      logic       start;
      logic [7:0] data;
   } crc_cmd_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

// ----- hdl/fbc_req_if.sv -----
// ----------------------------------------------------------------------------
// fbc_req_if
// Request channel: packet start and payload byte transactions.
// ----------------------------------------------------------------------------
interface fbc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] packet_length;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output packet_length, output data_byte,
                   input ready);
   modport sink (input valid, input mode, input packet_length, input data_byte,
                 output ready);
endinterface

// ----- hdl/fbc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fbc_rsp_if
// Response channel: framed and escaped line bytes.
// ----------------------------------------------------------------------------
interface fbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       frame_end;
   logic       last;

   modport source (output valid, output line_byte, output frame_end, output last,
                   input ready);
   modport sink (input valid, input line_byte, input frame_end, input last,
                 output ready);
endinterface

// ----- hdl/fbc_crc_unit.sv -----
// ----------------------------------------------------------------------------
// fbc_crc_unit
// Bit-serial reflected CRC-16: one polynomial step per cycle, eight per byte.
// ----------------------------------------------------------------------------
module fbc_crc_unit
   import fbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_cmd_type cmd,
   input  logic [15:0] polynomial,
   output logic [15:0] crc,
   output logic        busy
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [15:0] shifted;

   always_comb begin
      shifted  = {1'b0, crc_ff[15:1]};
      crc_in   = crc_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (cmd.seed) begin
         crc_in = CRC_INIT;
      end else if (cmd.start) begin
         crc_in   = crc_ff ^ {8'h00, cmd.data};
         count_in = 3'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         crc_in   = crc_ff[0] ? (shifted ^ polynomial) : shifted;
         count_in = count_ff + 3'd1;
         if (count_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= 3'd0;
         busy_ff  <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = busy_ff;

endmodule

// ----- hdl/fragmenting_frame_builder_crc16_core.sv -----
// ----------------------------------------------------------------------------
// fragmenting_frame_builder_crc16_core
// Cuts packets into fragments and sends each as a flagged, byte-stuffed frame
// with a CRC-16 or fixed check word.
//
//   channel | direction | transaction
//   req     | in        | packet start (mode 0, length) or payload byte (mode 1)
//   rsp     | out       | one line byte, frame_end on foot flag, last per request
//   csr     | in        | register write, index and data, no handshake
//
// Flags go from load straight to emit; each checked byte also passes through
// the bit-serial CRC unit, with an extra escape state for an inserted escape.
// A payload byte that closes a fragment also sends the trailer and, if packet
// bytes remain, the next header.
// req.ready is high only between requests; rsp stalls hold the sequencer.
// Reset is synchronous; CSRs and sequencer state reset, byte registers do not.
// ----------------------------------------------------------------------------
module fragmenting_frame_builder_crc16_core
   import fbc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   fbc_req_if.sink                    req,
   fbc_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [7:0]  sender_ff, receiver_ff, payload_max_ff;
   logic        protocol_ff, checksum_type_ff;
   logic [1:0]  message_type_ff;
   logic [15:0] polynomial_ff;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  pkt_rem_ff, pkt_rem_in;
   logic [7:0]  frag_rem_ff, frag_rem_in;
   logic [2:0]  idx_ff, idx_in;
   logic        final_ff, final_in;
   logic        active_ff, active_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  line_ff;
   logic        end_ff, last_ff;

   logic        emit, emit_end, emit_last;
   logic [7:0]  emit_byte, load_byte;
   logic [7:0]  eff_max, rem_src, frag_len;
   logic        frag_final, out_free;
   logic [15:0] chk, crc_value;
   logic        crc_busy;
   crc_cmd_type crc_cmd;

   fbc_crc_unit u_crc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (crc_cmd),
      .polynomial (polynomial_ff),
      .crc        (crc_value),
      .busy       (crc_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sender_ff        <= 8'd0;
         receiver_ff      <= 8'd0;
         payload_max_ff   <= PAYLOAD_MAX_RESET;
         protocol_ff      <= 1'b0;
         checksum_type_ff <= 1'b1;
         message_type_ff  <= 2'd0;
         polynomial_ff    <= POLY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SENDER_ADDRESS:   sender_ff        <= csr_write_data[7:0];
            CSR_RECEIVER_ADDRESS: receiver_ff      <= csr_write_data[7:0];
            CSR_PAYLOAD_MAX:      payload_max_ff   <= csr_write_data[7:0];
            CSR_PROTOCOL_BIT:     protocol_ff      <= csr_write_data[0];
            CSR_CHECKSUM_TYPE:    checksum_type_ff <= csr_write_data[0];
            CSR_MESSAGE_TYPE:     message_type_ff  <= csr_write_data[1:0];
            CSR_CRC_POLYNOMIAL:   polynomial_ff    <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      eff_max    = (payload_max_ff == 8'd0) ? 8'd1 : payload_max_ff;
      rem_src    = (state_ff == ST_IDLE) ? req.packet_length : pkt_rem_ff;
      frag_len   = (rem_src < eff_max) ? rem_src : eff_max;
      frag_final = (rem_src <= eff_max);
      chk        = checksum_type_ff ? crc_value : FIXED_CHECK;

      state_in    = state_ff;
      phase_in    = phase_ff;
      cur_in      = cur_ff;
      pkt_rem_in  = pkt_rem_ff;
      frag_rem_in = frag_rem_ff;
      idx_in      = idx_ff;
      final_in    = final_ff;
      active_in   = active_ff;
      crc_cmd     = '0;
      load_byte   = cur_ff;
      emit        = 1'b0;
      emit_byte   = cur_ff;
      emit_end    = 1'b0;
      emit_last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.mode == MODE_START) begin
                  idx_in      = 3'd0;
                  active_in   = (req.packet_length != 8'd0);
                  pkt_rem_in  = req.packet_length;
                  frag_rem_in = frag_len;
                  final_in    = frag_final;
                  phase_in    = PH_FLAG_OPEN;
                  state_in    = ST_LOAD;
               end else if (active_ff) begin
                  cur_in      = req.data_byte;
                  pkt_rem_in  = pkt_rem_ff - 8'd1;
                  frag_rem_in = frag_rem_ff - 8'd1;
                  phase_in    = PH_PAYLOAD;
                  state_in    = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            case (phase_ff)
               PH_FLAG_OPEN:  load_byte = FLAG_BYTE;
               PH_CTRL_HI:    load_byte = {idx_ff, final_ff, protocol_ff, message_type_ff,
                                           checksum_type_ff};
               PH_CTRL_LO:    load_byte = 8'h00;
               PH_SENDER:     load_byte = sender_ff;
               PH_RECEIVER:   load_byte = receiver_ff;
               PH_LEN:        load_byte = frag_rem_ff;
               PH_PAYLOAD:    load_byte = cur_ff;
               PH_CHK_HI:     load_byte = chk[15:8];
               PH_CHK_LO:     load_byte = chk[7:0];
               PH_FLAG_CLOSE: load_byte = FLAG_BYTE;
               default:       load_byte = cur_ff;
            endcase
            cur_in       = load_byte;
            crc_cmd.data = load_byte;
            if (phase_ff == PH_FLAG_OPEN) begin
               crc_cmd.seed = 1'b1;
               state_in     = ST_EMIT;
            end else if (phase_ff == PH_FLAG_CLOSE) begin
               state_in = ST_EMIT;
            end else if (phase_ff == PH_CHK_HI || phase_ff == PH_CHK_LO) begin
               state_in = is_special(load_byte) ? ST_ESC : ST_EMIT;
            end else begin
               crc_cmd.start = 1'b1;
               state_in      = ST_CRC;
            end
         end
         ST_CRC: begin
            if (!crc_busy) begin
               state_in = is_special(cur_ff) ? ST_ESC : ST_EMIT;
            end
         end
         ST_ESC: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = ESC_BYTE;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_LOAD;
               case (phase_ff)
                  PH_FLAG_OPEN: phase_in = PH_CTRL_HI;
                  PH_CTRL_HI:   phase_in = PH_CTRL_LO;
                  PH_CTRL_LO:   phase_in = PH_SENDER;
                  PH_SENDER:    phase_in = PH_RECEIVER;
                  PH_RECEIVER:  phase_in = PH_LEN;
                  PH_LEN, PH_PAYLOAD: begin
                     emit_last = (frag_rem_ff != 8'd0);
                     if (emit_last) begin
                        state_in = ST_IDLE;
                     end else begin
                        phase_in = PH_CHK_HI;
                     end
                  end
                  PH_CHK_HI:    phase_in = PH_CHK_LO;
                  PH_CHK_LO:    phase_in = PH_FLAG_CLOSE;
                  PH_FLAG_CLOSE: begin
                     emit_end  = 1'b1;
                     emit_last = (pkt_rem_ff == 8'd0);
                     if (emit_last) begin
                        active_in = 1'b0;
                        idx_in    = 3'd0;
                        state_in  = ST_IDLE;
                     end else begin
                        idx_in      = idx_ff + 3'd1;
                        frag_rem_in = frag_len;
                        final_in    = frag_final;
                        phase_in    = PH_FLAG_OPEN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FLAG_OPEN;
         pkt_rem_ff   <= 8'd0;
         frag_rem_ff  <= 8'd0;
         idx_ff       <= 3'd0;
         final_ff     <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pkt_rem_ff   <= pkt_rem_in;
         frag_rem_ff  <= frag_rem_in;
         idx_ff       <= idx_in;
         final_ff     <= final_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         line_ff <= emit_byte;
         end_ff  <= emit_end;
         last_ff <= emit_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.line_byte = line_ff;
   assign rsp.frame_end = end_ff;
   assign rsp.last      = last_ff;

   a_foot_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_ff |-> line_ff == FLAG_BYTE)
      else $error("frame end marked on a byte that is not a flag");

   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && active_ff |-> frag_rem_ff != 8'd0 && frag_rem_ff <= pkt_rem_ff)
      else $error("fragment count inconsistent with packet count");

   a_inactive_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !active_ff |-> pkt_rem_ff == 8'd0)
      else $error("packet bytes outstanding with no packet active");

   a_crc_start_idle: assert property (@(posedge clock) disable iff (reset)
      crc_cmd.start |-> !crc_busy && state_ff == ST_LOAD)
      else $error("crc started while busy");

   a_crc_busy_hold: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> state_ff == ST_CRC)
      else $error("sequencer left crc wait early");

endmodule
